>>> rtl/tpcc_pkg.sv
// ----------------------------------------------------------------------------
// tpcc_pkg: shared types and constants for the two-player countdown clock
// Holds phase and loser codes, register indexes, reset values and the
// struct types passed between the clock submodules.
// ----------------------------------------------------------------------------
`default_nettype none

package tpcc_pkg;

  localparam int unsigned KNOB_W  = 10;
  localparam int unsigned TIME_W  = 9;
  localparam int unsigned TICK_W  = 5;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned LOSER_W = 2;
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 10;
  localparam int unsigned IN_DW   = 16;
  localparam int unsigned OUT_DW  = 32;

  // phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_A_RUN = 2'd1;
  localparam logic [PHASE_W-1:0] PH_B_RUN = 2'd2;
  localparam logic [PHASE_W-1:0] PH_DONE  = 2'd3;

  // loser codes
  localparam logic [LOSER_W-1:0] LOSER_NONE = 2'd0;
  localparam logic [LOSER_W-1:0] LOSER_A    = 2'd1;
  localparam logic [LOSER_W-1:0] LOSER_B    = 2'd2;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_LOW_THR  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_HIGH_THR = 3'd1;
  localparam logic [CFG_AW-1:0] REG_SHORT    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_MID      = 3'd3;
  localparam logic [CFG_AW-1:0] REG_LONG     = 3'd4;
  localparam logic [CFG_AW-1:0] REG_TPS      = 3'd5;

  // register reset values
  localparam logic [KNOB_W-1:0] RST_LOW_THR  = 10'd341;
  localparam logic [KNOB_W-1:0] RST_HIGH_THR = 10'd682;
  localparam logic [TIME_W-1:0] RST_SHORT    = 9'd60;
  localparam logic [TIME_W-1:0] RST_MID      = 9'd180;
  localparam logic [TIME_W-1:0] RST_LONG     = 9'd300;
  localparam logic [TICK_W-1:0] RST_TPS      = 5'd20;

  typedef struct packed {
    logic [KNOB_W-1:0] low_thr;
    logic [KNOB_W-1:0] high_thr;
    logic [TIME_W-1:0] preset_short;
    logic [TIME_W-1:0] preset_mid;
    logic [TIME_W-1:0] preset_long;
    logic [TICK_W-1:0] tps;
  } cfg_t;

  typedef struct packed {
    logic [KNOB_W-1:0] knob_value;
    logic              knob_valid;
    logic              button_a;
    logic              button_b;
  } item_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [TIME_W-1:0]  time_a;
    logic [TIME_W-1:0]  time_b;
    logic [LOSER_W-1:0] loser;
    logic [TIME_W-1:0]  chosen_preset;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/tpcc_cfg.sv
// ----------------------------------------------------------------------------
// tpcc_cfg: configuration register file
// Write-only registers for thresholds, presets and the tick period.
// ----------------------------------------------------------------------------
`default_nettype none

module tpcc_cfg
  import tpcc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0] cfg_wdata,
  output cfg_t                   cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_thr      <= RST_LOW_THR;
      cfg_r.high_thr     <= RST_HIGH_THR;
      cfg_r.preset_short <= RST_SHORT;
      cfg_r.preset_mid   <= RST_MID;
      cfg_r.preset_long  <= RST_LONG;
      cfg_r.tps          <= RST_TPS;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LOW_THR:  cfg_r.low_thr      <= cfg_wdata[KNOB_W-1:0];
        REG_HIGH_THR: cfg_r.high_thr     <= cfg_wdata[KNOB_W-1:0];
        REG_SHORT:    cfg_r.preset_short <= cfg_wdata[TIME_W-1:0];
        REG_MID:      cfg_r.preset_mid   <= cfg_wdata[TIME_W-1:0];
        REG_LONG:     cfg_r.preset_long  <= cfg_wdata[TIME_W-1:0];
        REG_TPS:      cfg_r.tps          <= cfg_wdata[TICK_W-1:0];
        default:      ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> rtl/tpcc_core.sv
// ----------------------------------------------------------------------------
// tpcc_core: clock state and its single-pass update
// Holds phase, times, preset, tick counter, button history and loser.
// On step the state moves to its next value, which is also the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tpcc_core
  import tpcc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire item_t item,
  input  wire logic  step,
  output result_t    res
);

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [TIME_W-1:0]  time_a_r, time_a_nxt;
  logic [TIME_W-1:0]  time_b_r, time_b_nxt;
  logic [TIME_W-1:0]  preset_r, preset_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic [LOSER_W-1:0] loser_r, loser_nxt;
  logic               prev_a_r, prev_b_r;

  logic               edge_a, edge_b;
  logic [TIME_W-1:0]  pick;
  logic [TICK_W-1:0]  period, tick_inc;
  logic [TIME_W-1:0]  act_time, act_dec;
  logic               sec_due;

  assign edge_a = item.button_a & ~prev_a_r;
  assign edge_b = item.button_b & ~prev_b_r;

  // preset pick: mid range is tested first, also when thresholds cross
  always_comb begin
    if ((item.knob_value > cfg.low_thr) && (item.knob_value <= cfg.high_thr)) begin
      pick = cfg.preset_mid;
    end else if (item.knob_value > cfg.high_thr) begin
      pick = cfg.preset_long;
    end else begin
      pick = cfg.preset_short;
    end
  end

  assign period   = (cfg.tps == '0) ? TICK_W'(1) : cfg.tps;
  assign tick_inc = tick_r + TICK_W'(1);
  assign sec_due  = (tick_inc >= period);
  assign act_time = (phase_r == PH_A_RUN) ? time_a_r : time_b_r;
  assign act_dec  = (act_time != '0) ? act_time - TIME_W'(1) : act_time;

  always_comb begin
    phase_nxt  = phase_r;
    time_a_nxt = time_a_r;
    time_b_nxt = time_b_r;
    preset_nxt = preset_r;
    tick_nxt   = tick_r;
    loser_nxt  = loser_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (item.knob_valid && (pick != preset_r)) begin
          preset_nxt = pick;
          time_a_nxt = pick;
          time_b_nxt = pick;
        end
        if (preset_nxt != '0) begin
          if (edge_a) begin
            phase_nxt = PH_B_RUN;
            tick_nxt  = '0;
          end else if (edge_b) begin
            phase_nxt = PH_A_RUN;
            tick_nxt  = '0;
          end
        end
      end
      PH_A_RUN, PH_B_RUN: begin
        if ((phase_r == PH_A_RUN) ? edge_a : edge_b) begin
          phase_nxt = (phase_r == PH_A_RUN) ? PH_B_RUN : PH_A_RUN;
          tick_nxt  = '0;
        end else if (!sec_due) begin
          tick_nxt = tick_inc;
        end else begin
          tick_nxt = '0;
          if (phase_r == PH_A_RUN) time_a_nxt = act_dec;
          else                     time_b_nxt = act_dec;
          if (act_dec == '0) begin
            loser_nxt = (phase_r == PH_A_RUN) ? LOSER_A : LOSER_B;
            phase_nxt = PH_DONE;
          end
        end
      end
      PH_DONE: begin
        if (edge_a || edge_b) begin
          phase_nxt  = PH_IDLE;
          preset_nxt = '0;
          loser_nxt  = LOSER_NONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      time_a_r <= '0;
      time_b_r <= '0;
      preset_r <= '0;
      tick_r   <= '0;
      loser_r  <= LOSER_NONE;
      prev_a_r <= 1'b1;
      prev_b_r <= 1'b1;
    end else if (step) begin
      phase_r  <= phase_nxt;
      time_a_r <= time_a_nxt;
      time_b_r <= time_b_nxt;
      preset_r <= preset_nxt;
      tick_r   <= tick_nxt;
      loser_r  <= loser_nxt;
      prev_a_r <= item.button_a;
      prev_b_r <= item.button_b;
    end
  end

  assign res.phase         = phase_nxt;
  assign res.time_a        = time_a_nxt;
  assign res.time_b        = time_b_nxt;
  assign res.loser         = loser_nxt;
  assign res.chosen_preset = preset_nxt;

endmodule

`default_nettype wire

>>> rtl/two_player_countdown_clock_unit.sv
// ----------------------------------------------------------------------------
// two_player_countdown_clock_unit: two-player countdown (chess) clock
// Each input transfer is one sample tick: knob reading plus button levels.
// Each tick yields exactly one result transfer showing the updated clock.
//
// Usage:
//  - in_*  : one transfer per sample tick. tdata = knob value and the two
//            button levels, tuser = knob reading valid flag.
//  - out_* : one transfer per accepted tick with phase, both times, loser
//            and the loaded preset, as they stand after that tick.
//  - cfg_* : write-only registers (thresholds, presets, ticks per second);
//            write them only while no tick is in flight.
// Path: a tick passes the input register, then the result register; the
//   result register loads only once it is free or draining, so out_tvalid
//   can be held back while out_tready is low.
// Throughput: one tick per cycle unless out_tready stalls; the state update
//   is a single short pass from the input register to the result register.
// Reset: rst_n low clears the clock to idle with no preset, both times 0,
//   loser none and button history high; registers take their default values.
// Stall: when out_tready is low a full result register holds; an empty input
//   register still takes one more tick, after which in_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module two_player_countdown_clock_unit
  import tpcc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // [9:0] knob_value, [10] button_a, [11] button_b, [15:12] zero
  input  wire logic [IN_DW-1:0]  in_tdata,
  // [0] knob_valid
  input  wire logic              in_tuser,
  // result channel
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // [1:0] phase, [10:2] time_a, [19:11] time_b, [21:20] loser,
  // [30:22] chosen_preset, [31] zero
  output logic [OUT_DW-1:0]      out_tdata,
  // configuration write port
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0] cfg_wdata
);

  cfg_t    cfg;
  item_t   item_r;
  logic    item_vld_r;
  logic    step;
  result_t res;
  result_t res_r;
  logic    res_vld_r;

  tpcc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // the held tick moves on whenever the result register is free or draining
  assign step      = item_vld_r && (!res_vld_r || out_tready);
  assign in_tready = !item_vld_r || step;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.knob_value <= in_tdata[KNOB_W-1:0];
      item_r.button_a   <= in_tdata[KNOB_W];
      item_r.button_b   <= in_tdata[KNOB_W+1];
      item_r.knob_valid <= in_tuser;
    end
  end

  tpcc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .item  (item_r),
    .step  (step),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (step) begin
      res_vld_r <= 1'b1;
    end else if (out_tready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = res_vld_r;
  assign out_tdata  = {1'b0, res_r.chosen_preset, res_r.loser,
                       res_r.time_b, res_r.time_a, res_r.phase};

  // a finished game always names a loser, any other phase names none
  a_done_loser: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld_r && res_r.phase == PH_DONE) |-> (res_r.loser == LOSER_A ||
                                               res_r.loser == LOSER_B))
    else $error("finished phase without a loser");

  a_live_no_loser: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld_r && res_r.phase != PH_DONE) |-> (res_r.loser == LOSER_NONE))
    else $error("loser reported outside finished phase");

  // a running clock always has a preset loaded
  a_run_preset: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld_r && (res_r.phase == PH_A_RUN || res_r.phase == PH_B_RUN))
      |-> (res_r.chosen_preset != '0))
    else $error("clock running with no preset");

  // a held tick is not dropped while the result side stalls
  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    (item_vld_r && !step) |=> item_vld_r)
    else $error("input register lost a tick");

endmodule

`default_nettype wire

>>> test/two_player_countdown_clock_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_player_countdown_clock_checker: scoreboard for the countdown clock
// Watches tick, result and register-write traffic, keeps a private model of
// the clock, and compares every result transfer field by field against the
// oldest queued prediction.
// ----------------------------------------------------------------------------
module two_player_countdown_clock_checker
  import tpcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,
  input  logic              in_tuser,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_DW-1:0] out_tdata,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output int                mismatches,
  output int                pending,
  output int                results_checked,
  output int                games_decided
);

  // register copy
  logic [KNOB_W-1:0] thr_low, thr_high;
  logic [TIME_W-1:0] secs_short, secs_mid, secs_long;
  logic [TICK_W-1:0] ticks_per_sec;

  // clock state
  logic [PHASE_W-1:0] clock_phase;
  logic [TIME_W-1:0]  secs_a, secs_b, loaded;
  logic [TICK_W-1:0]  tick_cnt;
  logic               last_a, last_b;
  logic [LOSER_W-1:0] loser_code;

  result_t clock_face_q[$];

  initial begin
    mismatches      = 0;
    pending         = 0;
    results_checked = 0;
    games_decided   = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: result %0d %s: got %0d, want %0d", $time, results_checked, what, got, want);
    mismatches++;
  endtask

  task automatic clear_clock();
    thr_low       = RST_LOW_THR;
    thr_high      = RST_HIGH_THR;
    secs_short    = RST_SHORT;
    secs_mid      = RST_MID;
    secs_long     = RST_LONG;
    ticks_per_sec = RST_TPS;
    clock_phase   = PH_IDLE;
    secs_a        = '0;
    secs_b        = '0;
    loaded        = '0;
    tick_cnt      = '0;
    last_a        = 1'b1;
    last_b        = 1'b1;
    loser_code    = LOSER_NONE;
  endtask

  function automatic logic [TIME_W-1:0] preset_for(input logic [KNOB_W-1:0] knob);
    // mid is tested first, so crossed thresholds still resolve the same way
    if (knob > thr_low && knob <= thr_high) return secs_mid;
    if (knob > thr_high) return secs_long;
    return secs_short;
  endfunction

  task automatic count_second();
    logic [TICK_W-1:0] period;
    logic              ran_out;
    period   = (ticks_per_sec == '0) ? TICK_W'(1) : ticks_per_sec;
    tick_cnt = tick_cnt + 1'b1;
    if (tick_cnt >= period) begin
      tick_cnt = '0;
      if (clock_phase == PH_A_RUN) begin
        if (secs_a != '0) secs_a = secs_a - 1'b1;
        ran_out = (secs_a == '0);
      end else begin
        if (secs_b != '0) secs_b = secs_b - 1'b1;
        ran_out = (secs_b == '0);
      end
      if (ran_out) begin
        loser_code  = (clock_phase == PH_A_RUN) ? LOSER_A : LOSER_B;
        clock_phase = PH_DONE;
        games_decided++;
      end
    end
  endtask

  task automatic advance_clock(input item_t tk, output result_t face);
    logic              rise_a, rise_b;
    logic [TIME_W-1:0] pick;
    rise_a = tk.button_a && !last_a;
    rise_b = tk.button_b && !last_b;
    last_a = tk.button_a;
    last_b = tk.button_b;
    case (clock_phase)
      PH_IDLE: begin
        if (tk.knob_valid) begin
          pick = preset_for(tk.knob_value);
          if (pick != loaded) begin
            loaded = pick;
            secs_a = pick;
            secs_b = pick;
          end
        end
        // no start without a loaded preset; A's button wins a tie
        if (loaded != '0) begin
          if (rise_a) begin
            clock_phase = PH_B_RUN;
            tick_cnt    = '0;
          end else if (rise_b) begin
            clock_phase = PH_A_RUN;
            tick_cnt    = '0;
          end
        end
      end
      PH_A_RUN: begin
        if (rise_a) begin
          clock_phase = PH_B_RUN;
          tick_cnt    = '0;
        end else begin
          count_second();
        end
      end
      PH_B_RUN: begin
        if (rise_b) begin
          clock_phase = PH_A_RUN;
          tick_cnt    = '0;
        end else begin
          count_second();
        end
      end
      default: begin
        if (rise_a || rise_b) begin
          clock_phase = PH_IDLE;
          loaded      = '0;
          loser_code  = LOSER_NONE;
        end
      end
    endcase
    face.phase         = clock_phase;
    face.time_a        = secs_a;
    face.time_b        = secs_b;
    face.loser         = loser_code;
    face.chosen_preset = loaded;
  endtask

  always @(posedge clk) begin : watch
    item_t   tk;
    result_t want, got;
    if (!rst_n) begin
      clear_clock();
      clock_face_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_LOW_THR:  thr_low       = cfg_wdata[KNOB_W-1:0];
          REG_HIGH_THR: thr_high      = cfg_wdata[KNOB_W-1:0];
          REG_SHORT:    secs_short    = cfg_wdata[TIME_W-1:0];
          REG_MID:      secs_mid      = cfg_wdata[TIME_W-1:0];
          REG_LONG:     secs_long     = cfg_wdata[TIME_W-1:0];
          REG_TPS:      ticks_per_sec = cfg_wdata[TICK_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        tk.knob_value = in_tdata[9:0];
        tk.button_a   = in_tdata[10];
        tk.button_b   = in_tdata[11];
        tk.knob_valid = in_tuser;
        advance_clock(tk, want);
        clock_face_q.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.phase         = out_tdata[1:0];
        got.time_a        = out_tdata[10:2];
        got.time_b        = out_tdata[19:11];
        got.loser         = out_tdata[21:20];
        got.chosen_preset = out_tdata[30:22];
        if (clock_face_q.size() == 0) begin
          report_mismatch("unexpected result, raw data", out_tdata, 0);
        end else begin
          want = clock_face_q.pop_front();
          if (got.phase != want.phase) report_mismatch("phase", got.phase, want.phase);
          if (got.time_a != want.time_a) report_mismatch("time_a", got.time_a, want.time_a);
          if (got.time_b != want.time_b) report_mismatch("time_b", got.time_b, want.time_b);
          if (got.loser != want.loser) report_mismatch("loser", got.loser, want.loser);
          if (got.chosen_preset != want.chosen_preset)
            report_mismatch("chosen_preset", got.chosen_preset, want.chosen_preset);
        end
        results_checked++;
      end
    end
    pending <= clock_face_q.size();
  end

endmodule

>>> test/tb_two_player_countdown_clock_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_player_countdown_clock_unit: testbench for the countdown clock
// Drives sample ticks through the input stream with random gaps and result
// back-pressure, replays matches under a series of register settings and
// lets the checker score every result transfer.
// ----------------------------------------------------------------------------
module tb_two_player_countdown_clock_unit;
  import tpcc_pkg::*;

  // unmapped register index, writes there must be ignored
  localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd7;
  localparam int NUM_SETTINGS   = 10;
  localparam int TICKS_PER_SET  = 95;
  localparam int IDLE_PCT       = 38;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata   = '0;  // [9:0] knob_value, [10] button_a, [11] button_b
  logic              in_tuser   = 1'b0; // [0] knob_valid
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;  // [1:0] phase, [10:2] time_a, [19:11] time_b,
                                 // [21:20] loser, [30:22] chosen_preset
  logic              cfg_we     = 1'b0;
  logic [CFG_AW-1:0] cfg_addr   = '0;
  logic [CFG_DW-1:0] cfg_wdata  = '0;

  int mismatches, pending, results_checked, games_decided;
  int ticks_sent;
  bit no_idle;  // set for the back-to-back stretch on both sides

  // TB copy of the thresholds, used to aim knob readings at the boundaries
  logic [KNOB_W-1:0] thr_lo, thr_hi;
  logic [TIME_W-1:0] p_short, p_mid, p_long;
  logic [TICK_W-1:0] tps_v;
  bit                dirty;  // junk in unused upper write bits
  bit                lvl_a, lvl_b;
  int                press_pct;

  two_player_countdown_clock_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  two_player_countdown_clock_checker clock_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked),
    .games_decided   (games_decided)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop; far above the slowest legal run (~1k ticks).
  initial begin
    #5_000_000;
    $display("tb_two_player_countdown_clock_unit: errors");
    $finish;
  end

  // Result side back-pressure: ready drops ~38% of cycles unless in the
  // no-idle stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // One tick transfer. tvalid stays high after the handshake; the next call
  // (or drain) assigns it in the same time step, so there is only one write.
  task automatic send_tick(input logic [KNOB_W-1:0] knob, input logic valid,
                           input logic a, input logic b);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, b, a, knob};
    in_tuser  <= valid;
    do @(posedge clk); while (!in_tready);
    ticks_sent++;
  endtask

  // Hold the sender until every queued result has come back, then let the
  // two-stage pipe settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Writes the whole register set from thr_lo..tps_v; only called when drained.
  task automatic load_settings();
    put_reg(REG_LOW_THR, thr_lo);
    put_reg(REG_HIGH_THR, thr_hi);
    put_reg(REG_SHORT, {dirty ? 1'($urandom) : 1'b0, p_short});
    put_reg(REG_MID, {dirty ? 1'($urandom) : 1'b0, p_mid});
    put_reg(REG_LONG, {dirty ? 1'($urandom) : 1'b0, p_long});
    put_reg(REG_TPS, {dirty ? 5'($urandom) : 5'b0, tps_v});
    put_reg(REG_UNUSED, 10'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Knob reading: half uniform, half right around one of the thresholds.
  function automatic logic [KNOB_W-1:0] pick_knob();
    int v;
    if ($urandom_range(0, 1)) return 10'($urandom);
    v = ($urandom_range(0, 1) ? int'(thr_lo) : int'(thr_hi)) + $urandom_range(0, 2) - 1;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[KNOB_W-1:0];
  endfunction

  initial begin
    ticks_sent = 0;
    no_idle    = 1'b0;
    lvl_a      = 1'b0;
    lvl_b      = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed, at reset register values ----
    send_tick(10'd0, 1'b0, 1'b1, 1'b1);     // button history resets high: no edge
    send_tick(10'd0, 1'b0, 1'b0, 1'b0);
    send_tick(10'd0, 1'b0, 1'b1, 1'b0);     // edge with no preset loaded: ignored
    send_tick(10'd0, 1'b1, 1'b0, 1'b0);     // bottom of range -> short
    send_tick(10'd1023, 1'b1, 1'b0, 1'b0);  // top of range -> long
    send_tick(10'd341, 1'b1, 1'b0, 1'b0);   // on low threshold -> short
    send_tick(10'd342, 1'b1, 1'b0, 1'b0);   // just above -> mid
    send_tick(10'd682, 1'b1, 1'b0, 1'b0);   // on high threshold -> mid
    send_tick(10'd683, 1'b1, 1'b0, 1'b0);   // just above -> long
    send_tick(10'd0, 1'b0, 1'b0, 1'b0);     // invalid reading keeps the preset
    send_tick(10'd1023, 1'b0, 1'b1, 1'b1);  // both edges: A wins, B starts
    send_tick(10'd0, 1'b1, 1'b1, 1'b0);     // valid knob ignored while running
    send_tick(10'd0, 1'b0, 1'b0, 1'b1);     // B hands over to A
    send_tick(10'd0, 1'b0, 1'b0, 1'b0);
    send_tick(10'd0, 1'b0, 1'b0, 1'b1);     // other player's button ignored
    send_tick(10'd0, 1'b0, 1'b1, 1'b0);     // A hands over to B
    send_tick(10'd0, 1'b0, 1'b0, 1'b0);
    drain();

    // ---- random matches under a series of register settings ----
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      dirty = 1'b0;
      case (s)
        0: begin  // widest mid band, one-tick seconds via a zero period
          thr_lo = 10'd0;    thr_hi = 10'd1023;
          p_short = 9'd1; p_mid = 9'd2; p_long = 9'd1; tps_v = 5'd0;
        end
        1: begin  // crossed thresholds: mid unreachable
          thr_lo = 10'd1023; thr_hi = 10'd0;
          p_short = 9'd3; p_mid = 9'd511; p_long = 9'd2; tps_v = 5'd1;
        end
        2: begin  // zero short preset means nothing loaded, slowest period
          thr_lo = 10'd0;    thr_hi = 10'd0;
          p_short = 9'd0; p_mid = 9'd2; p_long = 9'd4; tps_v = 5'd31;
        end
        3: begin  // largest presets; matches only run partway
          thr_lo = 10'd500;  thr_hi = 10'd600;
          p_short = 9'd511; p_mid = 9'd511; p_long = 9'd511; tps_v = 5'd31;
        end
        default: begin
          thr_lo  = 10'($urandom);
          thr_hi  = 10'($urandom);
          p_short = 9'($urandom_range(0, 6));
          p_mid   = 9'($urandom_range(1, 6));
          p_long  = 9'($urandom_range(1, 6));
          tps_v   = 5'($urandom_range(0, 4));
          dirty   = 1'b1;
        end
      endcase
      load_settings();
      press_pct = $urandom_range(5, 25);
      no_idle   = (s == 5);
      for (int n = 0; n < TICKS_PER_SET; n++) begin
        // button levels as press/release sequences so edges stay realistic
        if (lvl_a) lvl_a = ($urandom_range(0, 99) >= 70);
        else       lvl_a = ($urandom_range(0, 99) < press_pct);
        if (lvl_b) lvl_b = ($urandom_range(0, 99) >= 70);
        else       lvl_b = ($urandom_range(0, 99) < press_pct);
        send_tick(pick_knob(), $urandom_range(0, 99) < 70, lvl_a, lvl_b);
        if (s == 6 && n == 47) drain();  // mid-match hold-off
      end
      drain();
    end
    no_idle = 1'b0;
    repeat (6) @(posedge clk);

    $display("coverage: %0d ticks over %0d register settings, %0d results compared",
             ticks_sent, NUM_SETTINGS + 1, results_checked);
    $display("coverage: %0d matches ended on time", games_decided);
    if (mismatches == 0) begin
      $display("tb_two_player_countdown_clock_unit: clean");
    end else begin
      $display("tb_two_player_countdown_clock_unit: errors");
    end
    $finish;
  end

endmodule
